// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants and types for the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOT_BITS  = 8;
	localparam int SLOTS      = 1 << SLOT_BITS;
	localparam int KEY_BITS   = 32;
	localparam int KEY_BYTES  = KEY_BITS / 8;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = SLOT_BITS + 1;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

	localparam logic [2:0] CMD_PUT      = 3'd0;
	localparam logic [2:0] CMD_GET      = 3'd1;
	localparam logic [2:0] CMD_REMOVE   = 3'd2;
	localparam logic [2:0] CMD_CONTAINS = 3'd3;
	localparam logic [2:0] CMD_CLEAR    = 3'd4;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_OCC   = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} hash_ctl_t;

endpackage

// ===== rtl/lpht_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_hash
// iterative fnv-1a over four key bytes, one byte per pass
// ----------------------------------------------------------------------------
module lpht_hash import lpht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [KEY_BITS-1:0]   key,
	output hash_ctl_t             ctl,
	output logic [SLOT_BITS-1:0]  home
);
	logic [63:0]           h_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [2:0]            cnt_q;
	logic                  busy_q, done_q;
	logic [63:0]           x, prod;

	// the prime is 2^40 + 0x1b3, so the product mod 2^64 is a shift plus a
	// narrow multiply; one byte a cycle
	assign x    = h_q ^ {56'd0, key_q[7:0]};
	assign prod = (x << 40) + (x * 64'h1b3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(KEY_BYTES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q   <= FNV_BASIS;
			key_q <= key;
		end else if (busy_q) begin
			h_q   <= prod;
			key_q <= key_q >> 8;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
	assign home      = h_q[SLOT_BITS-1:0];
endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// open addressing key/value table, fnv-1a hash, linear probing
// ----------------------------------------------------------------------------
// channel | direction | fields
// in      | sink      | command, key, value
// out     | source    | status, found, read_value, slot_index, live_entries
//
// a lookup passes from acceptance to a valid result through the hash (load,
// four bytes, hand-over), a registered memory read then a compare for each
// probed slot, and a final state that presents the result;
// a get adds a value read, and a walk may cover all 256 slots
// an unused command answers straight from idle; clear and reset run a wipe
// of all 256 marks, taking no input meanwhile
// one transaction at a time; a result held by the receiver blocks the next input
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit import lpht_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            command,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic                  found,
	output logic [VALUE_BITS-1:0] read_value,
	output logic [SLOT_BITS-1:0]  slot_index,
	output logic [COUNT_BITS-1:0] live_entries
);
	typedef enum logic [2:0] {
		S_WIPE, S_IDLE, S_HASH, S_RD, S_CHK, S_VAL, S_DONE
	} state_t;

	state_t                state_q;
	logic [2:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SLOT_BITS-1:0]  idx_q, tomb_idx_q, wipe_q;
	logic [COUNT_BITS-1:0] steps_q, live_q, tomb_q;
	logic                  have_tomb_q;
	logic                  hash_start;
	hash_ctl_t             hctl;
	logic [SLOT_BITS-1:0]  home;

	// memories
	logic [1:0]            marks_mem [SLOTS];
	logic [KEY_BITS-1:0]   key_mem   [SLOTS];
	logic [VALUE_BITS-1:0] val_mem   [SLOTS];
	logic [1:0]            mark_rd_q;
	logic [KEY_BITS-1:0]   key_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;

	logic                  mk_we, kv_we, vv_we;
	logic [SLOT_BITS-1:0]  wr_addr;
	logic [1:0]            mk_wdata;

	lpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (key_q),
		.ctl    (hctl),
		.home   (home)
	);

	logic accept, out_free;
	assign out_free   = !out_valid || out_ready;
	assign in_ready   = (state_q == S_IDLE) && out_free;
	assign accept     = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
			val_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (mk_we) marks_mem[wr_addr] <= mk_wdata;
		if (kv_we) key_mem[wr_addr]   <= key_q;
		if (vv_we) val_mem[wr_addr]   <= val_q;
		mark_rd_q <= marks_mem[idx_q];
		key_rd_q  <= key_mem[idx_q];
		val_rd_q  <= val_mem[idx_q];
	end

	// hash start is registered, so it comes in the cycle after accept, once key_q is loaded
	logic hit_now, walk_end;
	assign hit_now = (mark_rd_q == MARK_OCC) && (key_rd_q == key_q);

	always_comb begin
		mk_we    = 1'b0;
		kv_we    = 1'b0;
		vv_we    = 1'b0;
		wr_addr  = idx_q;
		mk_wdata = MARK_EMPTY;
		walk_end = (steps_q == COUNT_BITS'(SLOTS - 1));
		if (state_q == S_WIPE) begin
			mk_we   = 1'b1;
			wr_addr = wipe_q;
		end else if (state_q == S_CHK) begin
			if (hit_now) begin
				if (cmd_q == CMD_PUT) vv_we = 1'b1;
				if (cmd_q == CMD_REMOVE) begin
					mk_we    = 1'b1;
					mk_wdata = MARK_TOMB;
				end
			end else if (cmd_q == CMD_PUT && (mark_rd_q == MARK_EMPTY ||
					(walk_end && have_tomb_q))) begin
				mk_we    = 1'b1;
				kv_we    = 1'b1;
				vv_we    = 1'b1;
				mk_wdata = MARK_OCC;
				if (have_tomb_q) wr_addr = tomb_idx_q;
			end else if (cmd_q == CMD_PUT && walk_end && mark_rd_q == MARK_TOMB &&
					!have_tomb_q) begin
				mk_we    = 1'b1;
				kv_we    = 1'b1;
				vv_we    = 1'b1;
				mk_wdata = MARK_OCC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			wipe_q      <= '0;
			live_q      <= '0;
			tomb_q      <= '0;
			out_valid   <= 1'b0;
			hash_start  <= 1'b0;
			steps_q     <= '0;
			have_tomb_q <= 1'b0;
			idx_q       <= '0;
			tomb_idx_q  <= '0;
			status      <= ST_OK;
			found       <= 1'b0;
			read_value  <= '0;
			slot_index  <= '0;
			live_entries <= '0;
		end else begin
			hash_start <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_WIPE: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == SLOT_BITS'(SLOTS - 1)) begin
						if (cmd_q == CMD_CLEAR && out_free && steps_q[0]) begin
							out_valid    <= 1'b1;
							status       <= ST_OK;
							found        <= 1'b0;
							read_value   <= '0;
							slot_index   <= '0;
							live_entries <= '0;
						end
						steps_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_CLEAR) begin
							wipe_q  <= '0;
							live_q  <= '0;
							tomb_q  <= '0;
							steps_q <= COUNT_BITS'(1);
							state_q <= S_WIPE;
						end else if (command > CMD_CLEAR) begin
							out_valid    <= 1'b1;
							status       <= ST_OK;
							found        <= 1'b0;
							read_value   <= '0;
							slot_index   <= '0;
							live_entries <= live_q;
						end else begin
							hash_start <= 1'b1;
							state_q    <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hctl.done) begin
						idx_q       <= home;
						steps_q     <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					status     <= ST_OK;
					found      <= 1'b0;
					read_value <= '0;
					slot_index <= '0;
					if (hit_now) begin
						found      <= 1'b1;
						slot_index <= idx_q;
						if (cmd_q == CMD_REMOVE) begin
							live_q <= live_q - 1'b1;
							tomb_q <= tomb_q + 1'b1;
							live_entries <= live_q - 1'b1;
						end else begin
							live_entries <= live_q;
						end
						state_q <= (cmd_q == CMD_GET) ? S_VAL : S_DONE;
					end else if (mark_rd_q == MARK_EMPTY || walk_end) begin
						live_entries <= live_q;
						if (cmd_q != CMD_PUT) begin
							status <= ST_NOTFOUND;
						end else if (mark_rd_q == MARK_EMPTY || have_tomb_q ||
								mark_rd_q == MARK_TOMB) begin
							slot_index <= (have_tomb_q) ? tomb_idx_q : idx_q;
							live_q     <= live_q + 1'b1;
							live_entries <= live_q + 1'b1;
							if (have_tomb_q || mark_rd_q == MARK_TOMB)
								tomb_q <= tomb_q - 1'b1;
						end else begin
							status <= ST_FULL;
						end
						state_q <= S_DONE;
					end else begin
						if (mark_rd_q == MARK_TOMB && !have_tomb_q) begin
							have_tomb_q <= 1'b1;
							tomb_idx_q  <= idx_q;
						end
						idx_q   <= idx_q + 1'b1;
						steps_q <= steps_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_VAL: begin
					read_value <= val_rd_q;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					out_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
